/* src/lcdns_pkg.sv */
// Shared types, constants and the control-store program for the character LCD
// nibble sequencer. Depends on nothing; used by lcdns_bin2bcd and the top level.
package lcdns_pkg;

    // Field widths fixed by the bus format.
    localparam int NUM_W      = 16;  // binary value to print
    localparam int BCD_DIGITS = 5;   // decimal digits needed for NUM_W bits
    localparam int BCD_W      = 4 * BCD_DIGITS;
    localparam int CNT_W      = 3;   // holds BCD_DIGITS
    localparam int WAIT_W     = 14;
    localparam int TIME_W     = 8;
    localparam int PC_W       = 5;
    localparam int PROG_LEN   = 19;

    // Divide by ten as a reciprocal multiplication: (v * 0xCCCD) >> 19 equals
    // floor(v / 10) for every NUM_W-bit value.
    localparam int              PROD_W      = 2 * NUM_W;
    localparam logic [NUM_W-1:0] DIV10_MUL  = 16'hCCCD;
    localparam int              DIV10_SHIFT = 19;

    // Configuration register indexes.
    localparam logic [7:0] REG_COMMAND_TIME = 8'd0;
    localparam logic [7:0] REG_CHAR_TIME    = 8'd1;

    // Reset values of the timing registers.
    localparam logic [TIME_W-1:0] COMMAND_TIME_RESET = 8'd10;
    localparam logic [TIME_W-1:0] CHAR_TIME_RESET    = 8'd20;

    // Wake-up timing: fixed enable-high time and the extra holds before it.
    localparam logic [TIME_W-1:0] WAKE_HIGH_US  = 8'd10;
    localparam logic [WAIT_W-1:0] WAKE_EXTRA_0  = 14'd15000;
    localparam logic [WAIT_W-1:0] WAKE_EXTRA_1  = 14'd5000;
    localparam logic [WAIT_W-1:0] WAKE_EXTRA_2  = 14'd100;
    localparam logic [WAIT_W-1:0] EXTRA_NONE    = 14'd0;
    localparam logic [WAIT_W-1:0] EXTRA_SHORT   = 14'd40;
    localparam logic [WAIT_W-1:0] EXTRA_CLEAR   = 14'd80;

    // Init command bytes and the ASCII digit high nibble.
    localparam logic [7:0] LCD_FUNCTION_SET = 8'h28;
    localparam logic [7:0] LCD_ENTRY_MODE   = 8'h06;
    localparam logic [7:0] LCD_DISPLAY_ON   = 8'h0E;
    localparam logic [7:0] LCD_CLEAR        = 8'h01;
    localparam logic [7:0] ASCII_ZERO       = 8'h30;
    localparam logic [3:0] WAKE_NIBBLE      = 4'h3;
    localparam logic [3:0] BUS4_NIBBLE      = 4'h2;

    typedef enum logic [1:0] {
        CMD_COMMAND = 2'd0,
        CMD_CHAR    = 2'd1,
        CMD_INIT    = 2'd2,
        CMD_NUMBER  = 2'd3
    } cmd_t;

    typedef enum logic {
        OP_EMIT    = 1'b0,
        OP_CONVERT = 1'b1
    } op_t;

    typedef enum logic [1:0] {
        NIB_CONST   = 2'd0,
        NIB_DATA_HI = 2'd1,
        NIB_DATA_LO = 2'd2,
        NIB_DIGIT   = 2'd3
    } nib_sel_t;

    typedef enum logic [1:0] {
        T_CMD  = 2'd0,
        T_CHAR = 2'd1,
        T_WAKE = 2'd2
    } time_sel_t;

    typedef enum logic [1:0] {
        SEQ_NEXT = 2'd0,
        SEQ_END  = 2'd1,
        SEQ_LOOP = 2'd2
    } seq_t;

    typedef struct packed {
        op_t                op;
        logic               rs;
        nib_sel_t           nib_sel;
        logic [3:0]         nib_const;
        time_sel_t          time_sel;
        logic [WAIT_W-1:0]  extra;
        seq_t               seq;
        logic [PC_W-1:0]    target;
    } cw_t;

    // Program entry points.
    localparam logic [PC_W-1:0] PC_COMMAND = 5'd0;
    localparam logic [PC_W-1:0] PC_CHAR    = 5'd2;
    localparam logic [PC_W-1:0] PC_INIT    = 5'd4;
    localparam logic [PC_W-1:0] PC_NUMBER  = 5'd16;
    localparam logic [PC_W-1:0] PC_DIGIT   = 5'd17;

    function automatic cw_t make_cw(op_t op, logic rs, nib_sel_t ns, logic [3:0] nc,
                                    time_sel_t ts, logic [WAIT_W-1:0] ex, seq_t sq,
                                    logic [PC_W-1:0] tg);
        cw_t w;
        w.op        = op;
        w.rs        = rs;
        w.nib_sel   = ns;
        w.nib_const = nc;
        w.time_sel  = ts;
        w.extra     = ex;
        w.seq       = sq;
        w.target    = tg;
        return w;
    endfunction

    function automatic logic [PC_W-1:0] entry_pc(cmd_t c);
        logic [PC_W-1:0] p;
        case (c)
            CMD_COMMAND: p = PC_COMMAND;
            CMD_CHAR:    p = PC_CHAR;
            CMD_INIT:    p = PC_INIT;
            CMD_NUMBER:  p = PC_NUMBER;
            default:     p = PC_COMMAND;
        endcase
        return p;
    endfunction

    // Control store: one word per step.
    function automatic cw_t rom_word(logic [PC_W-1:0] pc);
        cw_t w;
        case (pc)
            5'd0:  w = make_cw(OP_EMIT, 1'b0, NIB_DATA_HI, 4'h0, T_CMD, EXTRA_NONE,
                               SEQ_NEXT, PC_COMMAND);
            5'd1:  w = make_cw(OP_EMIT, 1'b0, NIB_DATA_LO, 4'h0, T_CMD, EXTRA_NONE,
                               SEQ_END, PC_COMMAND);
            5'd2:  w = make_cw(OP_EMIT, 1'b1, NIB_DATA_HI, 4'h0, T_CHAR, EXTRA_NONE,
                               SEQ_NEXT, PC_COMMAND);
            5'd3:  w = make_cw(OP_EMIT, 1'b1, NIB_DATA_LO, 4'h0, T_CHAR, EXTRA_NONE,
                               SEQ_END, PC_COMMAND);
            5'd4:  w = make_cw(OP_EMIT, 1'b0, NIB_CONST, WAKE_NIBBLE, T_WAKE, WAKE_EXTRA_0,
                               SEQ_NEXT, PC_COMMAND);
            5'd5:  w = make_cw(OP_EMIT, 1'b0, NIB_CONST, WAKE_NIBBLE, T_WAKE, WAKE_EXTRA_1,
                               SEQ_NEXT, PC_COMMAND);
            5'd6:  w = make_cw(OP_EMIT, 1'b0, NIB_CONST, WAKE_NIBBLE, T_WAKE, WAKE_EXTRA_2,
                               SEQ_NEXT, PC_COMMAND);
            5'd7:  w = make_cw(OP_EMIT, 1'b0, NIB_CONST, BUS4_NIBBLE, T_WAKE, EXTRA_NONE,
                               SEQ_NEXT, PC_COMMAND);
            5'd8:  w = make_cw(OP_EMIT, 1'b0, NIB_CONST, LCD_FUNCTION_SET[7:4], T_CMD,
                               EXTRA_NONE, SEQ_NEXT, PC_COMMAND);
            5'd9:  w = make_cw(OP_EMIT, 1'b0, NIB_CONST, LCD_FUNCTION_SET[3:0], T_CMD,
                               EXTRA_NONE, SEQ_NEXT, PC_COMMAND);
            5'd10: w = make_cw(OP_EMIT, 1'b0, NIB_CONST, LCD_ENTRY_MODE[7:4], T_CMD,
                               EXTRA_SHORT, SEQ_NEXT, PC_COMMAND);
            5'd11: w = make_cw(OP_EMIT, 1'b0, NIB_CONST, LCD_ENTRY_MODE[3:0], T_CMD,
                               EXTRA_NONE, SEQ_NEXT, PC_COMMAND);
            5'd12: w = make_cw(OP_EMIT, 1'b0, NIB_CONST, LCD_DISPLAY_ON[7:4], T_CMD,
                               EXTRA_SHORT, SEQ_NEXT, PC_COMMAND);
            5'd13: w = make_cw(OP_EMIT, 1'b0, NIB_CONST, LCD_DISPLAY_ON[3:0], T_CMD,
                               EXTRA_NONE, SEQ_NEXT, PC_COMMAND);
            5'd14: w = make_cw(OP_EMIT, 1'b0, NIB_CONST, LCD_CLEAR[7:4], T_CMD,
                               EXTRA_CLEAR, SEQ_NEXT, PC_COMMAND);
            5'd15: w = make_cw(OP_EMIT, 1'b0, NIB_CONST, LCD_CLEAR[3:0], T_CMD,
                               EXTRA_NONE, SEQ_END, PC_COMMAND);
            5'd16: w = make_cw(OP_CONVERT, 1'b1, NIB_CONST, 4'h0, T_CHAR, EXTRA_NONE,
                               SEQ_NEXT, PC_COMMAND);
            5'd17: w = make_cw(OP_EMIT, 1'b1, NIB_CONST, ASCII_ZERO[7:4], T_CHAR,
                               EXTRA_NONE, SEQ_NEXT, PC_COMMAND);
            5'd18: w = make_cw(OP_EMIT, 1'b1, NIB_DIGIT, 4'h0, T_CHAR, EXTRA_NONE,
                               SEQ_LOOP, PC_DIGIT);
            default: w = make_cw(OP_EMIT, 1'b0, NIB_CONST, 4'h0, T_CMD, EXTRA_NONE,
                                 SEQ_END, PC_COMMAND);
        endcase
        return w;
    endfunction

endpackage

/* src/lcdns_bin2bcd.sv */
// Binary to BCD converter: one decimal digit per cycle, least significant first,
// with the divide by ten done as a reciprocal multiplication.
// Depends on lcdns_pkg for widths and the reciprocal constant.
module lcdns_bin2bcd (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       start,
    input  logic [lcdns_pkg::NUM_W-1:0] bin_in,
    output logic                       done,
    output logic [lcdns_pkg::BCD_W-1:0] bcd_out
);

    logic [lcdns_pkg::NUM_W-1:0]  bin_reg;
    logic [lcdns_pkg::BCD_W-1:0]  bcd_reg;
    logic [lcdns_pkg::CNT_W-1:0]  cnt_reg;
    logic [lcdns_pkg::PROD_W-1:0] prod;
    logic [lcdns_pkg::NUM_W-1:0]  quot;
    logic [lcdns_pkg::NUM_W-1:0]  rem;

    // The quotient comes from the reciprocal product; the remainder is the value
    // minus ten times the quotient, built from two shifts.
    assign prod = lcdns_pkg::PROD_W'(bin_reg) * lcdns_pkg::PROD_W'(lcdns_pkg::DIV10_MUL);
    assign quot = lcdns_pkg::NUM_W'(prod[lcdns_pkg::PROD_W-1:lcdns_pkg::DIV10_SHIFT]);
    assign rem  = bin_reg - {quot[lcdns_pkg::NUM_W-4:0], 3'b000}
                          - {quot[lcdns_pkg::NUM_W-2:0], 1'b0};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= '0;
        end else if (start) begin
            cnt_reg <= lcdns_pkg::CNT_W'(lcdns_pkg::BCD_DIGITS);
        end else if (cnt_reg != '0) begin
            cnt_reg <= cnt_reg - 1'b1;
        end
    end

    // Each new digit enters at the top, so the first one ends up in the lowest nibble.
    always_ff @(posedge aclk) begin
        if (start) begin
            bin_reg <= bin_in;
            bcd_reg <= '0;
        end else if (cnt_reg != '0) begin
            bcd_reg <= {rem[3:0], bcd_reg[lcdns_pkg::BCD_W-1:4]};
            bin_reg <= quot;
        end
    end

    assign done    = (cnt_reg == '0);
    assign bcd_out = bcd_reg;

endmodule

/* src/char_lcd_nibble_sequencer_unit.sv */
// A byte or init request enters its first step when it is accepted, and that step
// loads the first result beat into the output register; a number request first
// waits in the decimal converter. Throughput: one pulse beat per cycle while the
// output is taken, outside the conversion step, since the microprogram step counter
// emits one beat per emit step; a new request is accepted only after the previous final beat.
// Reset: synchronous, active low; timing registers return to 10 us and 20 us.
module char_lcd_nibble_sequencer_unit #(
    parameter int DIGIT_COUNT = 4
) (
    input  logic        aclk,
    input  logic        aresetn,
    // Request channel.
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // [7:0] data_byte, [23:8] number
    input  logic [1:0]  s_tuser,   // [1:0] cmd
    // Pulse event channel.
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // [3:0] nibble, [17:4] wait_before_us,
                                   // [25:18] high_us, [31:26] zero
    output logic        m_tuser,   // [0] rs
    output logic        m_tlast,
    // Configuration write channel.
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [7:0]  cfg_index,
    input  logic [7:0]  cfg_data
);

    localparam int IDX_W = (DIGIT_COUNT > 1) ? $clog2(DIGIT_COUNT) : 1;
    localparam logic [IDX_W-1:0] IDX_FIRST = IDX_W'(DIGIT_COUNT - 1);

    // Timing registers.
    logic [lcdns_pkg::TIME_W-1:0] command_time_reg;
    logic [lcdns_pkg::TIME_W-1:0] char_time_reg;

    // Sequencer state.
    logic                       busy_reg;
    logic [lcdns_pkg::PC_W-1:0] pc_reg;
    logic [7:0]                 data_reg;
    logic [IDX_W-1:0]           idx_reg;

    // Output register.
    logic                         m_valid_reg;
    logic                         rs_reg;
    logic [3:0]                   nibble_reg;
    logic [lcdns_pkg::WAIT_W-1:0] wait_reg;
    logic [lcdns_pkg::TIME_W-1:0] high_reg;
    logic                         last_reg;

    logic                         s_fire;
    logic                         out_free;
    logic                         emit_fire;
    lcdns_pkg::cw_t               cw;
    logic [lcdns_pkg::TIME_W-1:0] t_sel;
    logic [3:0]                   nib_sel;
    logic                         last_w;
    logic                         bcd_start;
    logic                         bcd_done;
    logic [lcdns_pkg::BCD_W-1:0]  bcd;
    logic [3:0]                   digit [0:DIGIT_COUNT-1];

    assign s_tready  = !busy_reg;
    assign s_fire    = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;
    assign out_free  = !m_valid_reg || m_tready;

    // The current control word drives the whole datapath.
    assign cw        = lcdns_pkg::rom_word(pc_reg);
    assign emit_fire = busy_reg && (cw.op == lcdns_pkg::OP_EMIT) && out_free;

    // The converter starts on the number request's own accept cycle.
    assign bcd_start = s_fire && (lcdns_pkg::cmd_t'(s_tuser) == lcdns_pkg::CMD_NUMBER);

    lcdns_bin2bcd u_bin2bcd (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (bcd_start),
        .bin_in  (s_tdata[23:8]),
        .done    (bcd_done),
        .bcd_out (bcd)
    );

    // Only the low DIGIT_COUNT decimal digits are ever shown.
    for (genvar g = 0; g < DIGIT_COUNT; g++) begin : g_digit
        assign digit[g] = bcd[4*g +: 4];
    end

    always_comb begin
        case (cw.time_sel)
            lcdns_pkg::T_CMD:  t_sel = command_time_reg;
            lcdns_pkg::T_CHAR: t_sel = char_time_reg;
            lcdns_pkg::T_WAKE: t_sel = lcdns_pkg::WAKE_HIGH_US;
            default:           t_sel = command_time_reg;
        endcase
    end

    // A digit's low nibble is the digit itself, since ASCII '0' has a zero low nibble.
    always_comb begin
        case (cw.nib_sel)
            lcdns_pkg::NIB_CONST:   nib_sel = cw.nib_const;
            lcdns_pkg::NIB_DATA_HI: nib_sel = data_reg[7:4];
            lcdns_pkg::NIB_DATA_LO: nib_sel = data_reg[3:0];
            lcdns_pkg::NIB_DIGIT:   nib_sel = digit[idx_reg];
            default:                nib_sel = cw.nib_const;
        endcase
    end

    // The request ends on an END step, or on the digit loop's final pass.
    assign last_w = (cw.seq == lcdns_pkg::SEQ_END) ||
                    ((cw.seq == lcdns_pkg::SEQ_LOOP) && (idx_reg == '0));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            command_time_reg <= lcdns_pkg::COMMAND_TIME_RESET;
            char_time_reg    <= lcdns_pkg::CHAR_TIME_RESET;
        end else if (cfg_valid && cfg_ready) begin
            if (cfg_index == lcdns_pkg::REG_COMMAND_TIME) begin
                command_time_reg <= cfg_data;
            end else if (cfg_index == lcdns_pkg::REG_CHAR_TIME) begin
                char_time_reg <= cfg_data;
            end
        end
    end

    // Step counter with conditional jumps.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            pc_reg   <= '0;
            idx_reg  <= '0;
        end else if (s_fire) begin
            busy_reg <= 1'b1;
            pc_reg   <= lcdns_pkg::entry_pc(lcdns_pkg::cmd_t'(s_tuser));
            idx_reg  <= IDX_FIRST;
        end else if (busy_reg) begin
            if (cw.op == lcdns_pkg::OP_CONVERT) begin
                if (bcd_done) begin
                    pc_reg <= pc_reg + 1'b1;
                end
            end else if (emit_fire) begin
                case (cw.seq)
                    lcdns_pkg::SEQ_NEXT: begin
                        pc_reg <= pc_reg + 1'b1;
                    end
                    lcdns_pkg::SEQ_END: begin
                        busy_reg <= 1'b0;
                    end
                    lcdns_pkg::SEQ_LOOP: begin
                        if (idx_reg == '0) begin
                            busy_reg <= 1'b0;
                        end else begin
                            idx_reg <= idx_reg - 1'b1;
                            pc_reg  <= cw.target;
                        end
                    end
                    default: begin
                        busy_reg <= 1'b0;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_fire) begin
            data_reg <= s_tdata[7:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (emit_fire) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (emit_fire) begin
            rs_reg     <= cw.rs;
            nibble_reg <= nib_sel;
            wait_reg   <= cw.extra + lcdns_pkg::WAIT_W'(t_sel);
            high_reg   <= t_sel;
            last_reg   <= last_w;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {6'd0, high_reg, wait_reg, nibble_reg};
    assign m_tuser  = rs_reg;
    assign m_tlast  = last_reg;

    // An accepted request always starts the sequencer.
    a_accept_starts: assert property (@(posedge aclk) disable iff (!aresetn)
        s_fire |=> busy_reg)
        else $error("sequencer not busy after request accept");

    // The final beat of a request releases the sequencer.
    a_last_ends: assert property (@(posedge aclk) disable iff (!aresetn)
        (emit_fire && last_w) |=> !busy_reg)
        else $error("sequencer still busy after final beat");

    // The step counter never leaves the program.
    a_pc_range: assert property (@(posedge aclk) disable iff (!aresetn)
        busy_reg |-> (pc_reg < lcdns_pkg::PC_W'(lcdns_pkg::PROG_LEN)))
        else $error("step counter outside program");

    // Digits are only emitted once the conversion has finished.
    a_digit_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        (busy_reg && (cw.nib_sel == lcdns_pkg::NIB_DIGIT)) |-> bcd_done)
        else $error("digit emitted before conversion finished");

    // The digit index stays within the configured digit count.
    a_idx_range: assert property (@(posedge aclk) disable iff (!aresetn)
        busy_reg |-> (idx_reg <= IDX_FIRST))
        else $error("digit index out of range");

endmodule

/* tb/sv/lcd_pulse_checker.sv */
`timescale 1ns / 1ps
// Self-checking monitor for the character LCD nibble sequencer: it watches the
// request, pulse and configuration channels, predicts every pulse beat and compares.
// Depends on lcdns_pkg for the request codes, register indexes and LCD constants.
module lcd_pulse_checker #(
    parameter int DIGIT_COUNT = 4
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [23:0] s_tdata,   // [7:0] data_byte, [23:8] number
    input  logic [1:0]  s_tuser,   // [1:0] cmd
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [31:0] m_tdata,   // [3:0] nibble, [17:4] wait_before_us, [25:18] high_us
    input  logic        m_tuser,   // [0] rs
    input  logic        m_tlast,
    input  logic        cfg_valid,
    input  logic        cfg_ready,
    input  logic [7:0]  cfg_index,
    input  logic [7:0]  cfg_data,
    output int          mismatch_count,
    output int          pulses_pending,
    output int          requests_seen,
    output int          pulses_checked
);

    typedef struct packed {
        logic                         rs;
        logic [3:0]                   nibble;
        logic [lcdns_pkg::WAIT_W-1:0] wait_us;
        logic [lcdns_pkg::TIME_W-1:0] high_us;
        logic                         last;
    } lcd_pulse_t;

    lcd_pulse_t                   expected_pulses[$];
    logic [lcdns_pkg::TIME_W-1:0] command_time = lcdns_pkg::COMMAND_TIME_RESET;
    logic [lcdns_pkg::TIME_W-1:0] char_time    = lcdns_pkg::CHAR_TIME_RESET;
    int                           errors       = 0;
    int                           requests     = 0;
    int                           pulses       = 0;

    initial begin
        mismatch_count = 0;
        pulses_pending = 0;
        requests_seen  = 0;
        pulses_checked = 0;
    end

    function automatic void queue_pulse(logic rs, logic [3:0] nib,
                                        logic [lcdns_pkg::WAIT_W-1:0] hold,
                                        logic [lcdns_pkg::TIME_W-1:0] high, logic last);
        lcd_pulse_t p;
        p.rs      = rs;
        p.nibble  = nib;
        p.wait_us = hold;
        p.high_us = high;
        p.last    = last;
        expected_pulses.push_back(p);
    endfunction

    // A byte always goes out high nibble first; only the high nibble carries the extra hold.
    function automatic void queue_byte(logic rs, logic [7:0] b,
                                       logic [lcdns_pkg::TIME_W-1:0] t,
                                       logic [lcdns_pkg::WAIT_W-1:0] extra, logic last);
        queue_pulse(rs, b[7:4], extra + lcdns_pkg::WAIT_W'(t), t, 1'b0);
        queue_pulse(rs, b[3:0], lcdns_pkg::WAIT_W'(t), t, last);
    endfunction

    function automatic void sequence_request(lcdns_pkg::cmd_t c, logic [7:0] b,
                                             logic [15:0] n);
        logic [15:0] rest;
        logic [3:0]  digit [DIGIT_COUNT];
        case (c)
            lcdns_pkg::CMD_COMMAND:
                queue_byte(1'b0, b, command_time, lcdns_pkg::EXTRA_NONE, 1'b1);
            lcdns_pkg::CMD_CHAR:
                queue_byte(1'b1, b, char_time, lcdns_pkg::EXTRA_NONE, 1'b1);
            lcdns_pkg::CMD_INIT: begin
                queue_pulse(1'b0, lcdns_pkg::WAKE_NIBBLE,
                            lcdns_pkg::WAKE_EXTRA_0 +
                            lcdns_pkg::WAIT_W'(lcdns_pkg::WAKE_HIGH_US),
                            lcdns_pkg::WAKE_HIGH_US, 1'b0);
                queue_pulse(1'b0, lcdns_pkg::WAKE_NIBBLE,
                            lcdns_pkg::WAKE_EXTRA_1 +
                            lcdns_pkg::WAIT_W'(lcdns_pkg::WAKE_HIGH_US),
                            lcdns_pkg::WAKE_HIGH_US, 1'b0);
                queue_pulse(1'b0, lcdns_pkg::WAKE_NIBBLE,
                            lcdns_pkg::WAKE_EXTRA_2 +
                            lcdns_pkg::WAIT_W'(lcdns_pkg::WAKE_HIGH_US),
                            lcdns_pkg::WAKE_HIGH_US, 1'b0);
                queue_pulse(1'b0, lcdns_pkg::BUS4_NIBBLE,
                            lcdns_pkg::WAIT_W'(lcdns_pkg::WAKE_HIGH_US),
                            lcdns_pkg::WAKE_HIGH_US, 1'b0);
                queue_byte(1'b0, lcdns_pkg::LCD_FUNCTION_SET, command_time,
                           lcdns_pkg::EXTRA_NONE, 1'b0);
                queue_byte(1'b0, lcdns_pkg::LCD_ENTRY_MODE, command_time,
                           lcdns_pkg::EXTRA_SHORT, 1'b0);
                queue_byte(1'b0, lcdns_pkg::LCD_DISPLAY_ON, command_time,
                           lcdns_pkg::EXTRA_SHORT, 1'b0);
                queue_byte(1'b0, lcdns_pkg::LCD_CLEAR, command_time,
                           lcdns_pkg::EXTRA_CLEAR, 1'b1);
            end
            default: begin
                rest = n;
                for (int j = DIGIT_COUNT - 1; j >= 0; j--) begin
                    digit[j] = 4'(rest % 16'd10);
                    rest     = rest / 16'd10;
                end
                for (int j = 0; j < DIGIT_COUNT; j++)
                    queue_byte(1'b1, lcdns_pkg::ASCII_ZERO + 8'(digit[j]), char_time,
                               lcdns_pkg::EXTRA_NONE, j == DIGIT_COUNT - 1);
            end
        endcase
    endfunction

    function automatic void check_field(string name, logic [15:0] want, logic [15:0] got);
        if (got !== want) begin
            errors++;
            $display("%0t ns: pulse %s expected %0d, got %0d", $time, name, want, got);
        end
    endfunction

    always @(posedge aclk) begin : watch
        lcd_pulse_t want;
        if (!aresetn) begin
            command_time = lcdns_pkg::COMMAND_TIME_RESET;
            char_time    = lcdns_pkg::CHAR_TIME_RESET;
            expected_pulses.delete();
        end else begin
            if (cfg_valid && cfg_ready) begin
                if (cfg_index == lcdns_pkg::REG_COMMAND_TIME)
                    command_time = cfg_data;
                else if (cfg_index == lcdns_pkg::REG_CHAR_TIME)
                    char_time = cfg_data;
            end
            if (s_tvalid && s_tready) begin
                requests++;
                sequence_request(lcdns_pkg::cmd_t'(s_tuser), s_tdata[7:0], s_tdata[23:8]);
            end
            if (m_tvalid && m_tready) begin
                pulses++;
                if (expected_pulses.size() == 0) begin
                    errors++;
                    $display("%0t ns: pulse beat expected none, got rs=%0b tdata=%h last=%0b",
                             $time, m_tuser, m_tdata, m_tlast);
                end else begin
                    want = expected_pulses.pop_front();
                    check_field("rs", want.rs, m_tuser);
                    check_field("nibble", want.nibble, m_tdata[3:0]);
                    check_field("wait_before_us", want.wait_us, m_tdata[17:4]);
                    check_field("high_us", want.high_us, m_tdata[25:18]);
                    check_field("last", want.last, m_tlast);
                end
            end
        end
        mismatch_count <= errors;
        pulses_pending <= expected_pulses.size();
        requests_seen  <= requests;
        pulses_checked <= pulses;
    end

endmodule

/* tb/sv/tb_top.sv */
`timescale 1ns / 1ps
// Top of the nibble sequencer testbench: clock, reset, request and timing-register
// stimulus, output back-pressure and the final verdict. Depends on lcdns_pkg,
// char_lcd_nibble_sequencer_unit and lcd_pulse_checker.
module tb_top;

    localparam int DIGITS         = 4;
    localparam int RESET_CYCLES   = 9;
    localparam int IDLE_SETTLE    = 4;     // margin for the block to go idle after its last beat
    localparam int END_SETTLE     = 40;    // longer than a full number conversion
    localparam int LONG_HOLD      = 400;   // output held off while requests keep coming
    localparam int WATCHDOG_LIMIT = 3000;  // well above the long hold plus worst gaps
    localparam int RANDOM_PHASES  = 6;
    localparam int PHASE_ITEMS    = 21;

    logic        aclk      = 1'b0;
    logic        aresetn   = 1'b0;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    logic [23:0] s_tdata   = '0;
    logic [1:0]  s_tuser   = '0;
    logic        m_tvalid;
    logic        m_tready  = 1'b0;
    logic [31:0] m_tdata;
    logic        m_tuser;
    logic        m_tlast;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [7:0]  cfg_index = '0;
    logic [7:0]  cfg_data  = '0;

    int mismatch_count;
    int pulses_pending;
    int requests_seen;
    int pulses_checked;

    // Idling controls shared between the request side and the output side.
    bit tx_gaps     = 1'b0;
    bit rx_stalls   = 1'b0;
    bit hold_output = 1'b0;
    int idle_cycles = 0;
    int settings    = 1;     // the reset timing counts as the first setting

    always #5 aclk = ~aclk;

    char_lcd_nibble_sequencer_unit #(
        .DIGIT_COUNT(DIGITS)
    ) u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data (cfg_data)
    );

    lcd_pulse_checker #(
        .DIGIT_COUNT(DIGITS)
    ) u_checker (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_tvalid      (s_tvalid),
        .s_tready      (s_tready),
        .s_tdata       (s_tdata),
        .s_tuser       (s_tuser),
        .m_tvalid      (m_tvalid),
        .m_tready      (m_tready),
        .m_tdata       (m_tdata),
        .m_tuser       (m_tuser),
        .m_tlast       (m_tlast),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .mismatch_count(mismatch_count),
        .pulses_pending(pulses_pending),
        .requests_seen (requests_seen),
        .pulses_checked(pulses_checked)
    );

    // Offers one request beat and returns at the edge where it is taken. tvalid is
    // left high afterwards; the next call either keeps it high with new data or drops
    // it for a gap, so tvalid never gets two assignments in one time step.
    task automatic send_request(input lcdns_pkg::cmd_t c, input logic [7:0] b,
                                input logic [15:0] n);
        int gap;
        gap = tx_gaps ? $urandom_range(0, 19) : 0;
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {n, b};
        s_tuser  <= c;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
    endtask

    // Waits until every predicted pulse has come out, then lets the block go idle
    // so that a register write cannot land while it is still busy.
    // The first edge lets the checker count the request taken at the current edge.
    task automatic wait_idle();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (pulses_pending != 0) @(posedge aclk);
        repeat (IDLE_SETTLE) @(posedge aclk);
    endtask

    // One register write beat. The trailing edge keeps a following write from
    // lowering and raising cfg_valid in the same time step.
    task automatic write_reg(input logic [7:0] index, input logic [7:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= index;
        cfg_data  <= value;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        cfg_valid <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic set_timing(input logic [7:0] command_us, input logic [7:0] char_us);
        wait_idle();
        write_reg(lcdns_pkg::REG_COMMAND_TIME, command_us);
        write_reg(lcdns_pkg::REG_CHAR_TIME, char_us);
        settings++;
    endtask

    // Mostly values that fit the four displayed digits; now and then the full
    // 16-bit range so that the dropped upper digit gets exercised too.
    task automatic random_request();
        lcdns_pkg::cmd_t c;
        logic [15:0]     n;
        c = lcdns_pkg::cmd_t'($urandom_range(0, 3));
        if ($urandom_range(0, 3) == 0)
            n = 16'($urandom);
        else
            n = 16'($urandom_range(0, 9999));
        send_request(c, 8'($urandom), n);
    endtask

    // Output side: before every beat it draws a stall, unless stalls are switched
    // off for a stretch. A long hold-off request overrides the draw once.
    initial begin : rx_side
        int stall;
        @(posedge aclk);
        while (!aresetn) @(posedge aclk);
        forever begin
            if (hold_output) begin
                hold_output = 1'b0;
                stall = LONG_HOLD;
            end else if (rx_stalls) begin
                stall = $urandom_range(0, 19);
            end else begin
                stall = 0;
            end
            if (stall > 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_tready <= 1'b1;
            @(posedge aclk);
            while (!m_tvalid) @(posedge aclk);
        end
    end

    // Watchdog: any cycle without a beat on some channel counts toward the limit.
    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready) ||
                (cfg_valid && cfg_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t ns: watchdog expired, no beat for %0d cycles, %0d pulses pending",
                     $time, idle_cycles, pulses_pending);
            $display("SCOREBOARD MISMATCH");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin : stimulus
        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Reset timing, no idling: init sequence, byte extremes, number edge cases
        // (zero, largest four-digit value, first value that loses a digit, all ones).
        send_request(lcdns_pkg::CMD_INIT, 8'h00, 16'h0000);
        send_request(lcdns_pkg::CMD_COMMAND, 8'h00, 16'hFFFF);
        send_request(lcdns_pkg::CMD_COMMAND, 8'hFF, 16'h0000);
        send_request(lcdns_pkg::CMD_CHAR, 8'hA5, 16'h0000);
        send_request(lcdns_pkg::CMD_CHAR, 8'h5A, 16'hFFFF);
        send_request(lcdns_pkg::CMD_NUMBER, 8'hFF, 16'd0);
        send_request(lcdns_pkg::CMD_NUMBER, 8'h00, 16'd9999);
        send_request(lcdns_pkg::CMD_NUMBER, 8'h00, 16'd10000);
        send_request(lcdns_pkg::CMD_NUMBER, 8'h00, 16'd65535);

        // Shortest nonzero command time, longest character time, plus writes to indexes
        // that do not exist and must leave both registers alone.
        tx_gaps   = 1'b1;
        rx_stalls = 1'b1;
        set_timing(8'd1, 8'd255);
        write_reg(8'd2, 8'h77);
        write_reg(8'hFF, 8'h00);
        send_request(lcdns_pkg::CMD_INIT, 8'h00, 16'h0000);
        send_request(lcdns_pkg::CMD_COMMAND, 8'h81, 16'h0000);
        send_request(lcdns_pkg::CMD_CHAR, 8'h7E, 16'h0000);
        send_request(lcdns_pkg::CMD_NUMBER, 8'h00, 16'd4321);

        // The opposite extremes.
        set_timing(8'd255, 8'd1);
        send_request(lcdns_pkg::CMD_INIT, 8'h00, 16'h0000);
        send_request(lcdns_pkg::CMD_NUMBER, 8'h00, 16'd1);
        send_request(lcdns_pkg::CMD_COMMAND, 8'h3C, 16'h0000);
        send_request(lcdns_pkg::CMD_CHAR, 8'hC3, 16'h0000);

        // A timing register written as zero gives zero high time and only the extra hold as wait.
        set_timing(8'd0, 8'd0);
        send_request(lcdns_pkg::CMD_INIT, 8'h00, 16'h0000);
        send_request(lcdns_pkg::CMD_COMMAND, 8'h42, 16'h0000);
        send_request(lcdns_pkg::CMD_CHAR, 8'h24, 16'h0000);
        send_request(lcdns_pkg::CMD_NUMBER, 8'h00, 16'd12345);

        // Random phases, each under a fresh timing setting. Idling is redrawn at items 0 and 12
        // of a phase so that there are stretches without gaps on either side.
        for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
            case ($urandom_range(0, 3))
                0:       set_timing(8'd255, 8'($urandom_range(1, 255)));
                1:       set_timing(8'($urandom_range(1, 255)), 8'd1);
                default: set_timing(8'($urandom_range(1, 255)), 8'($urandom_range(1, 255)));
            endcase
            if ($urandom_range(0, 1) == 0)
                write_reg(8'($urandom_range(2, 255)), 8'($urandom));
            for (int k = 0; k < PHASE_ITEMS; k++) begin
                if (k % 12 == 0) begin
                    tx_gaps   = ($urandom_range(0, 3) != 0);
                    rx_stalls = ($urandom_range(0, 3) != 0);
                end
                random_request();
            end

            // Once, hold the output off for a long time while requests keep arriving
            // back to back, so the block fills up and has to stall its input.
            if (phase == RANDOM_PHASES / 2) begin
                tx_gaps     = 1'b0;
                hold_output = 1'b1;
                send_request(lcdns_pkg::CMD_INIT, 8'h00, 16'h0000);
                send_request(lcdns_pkg::CMD_NUMBER, 8'h00, 16'd8765);
                send_request(lcdns_pkg::CMD_CHAR, 8'($urandom), 16'h0000);
                send_request(lcdns_pkg::CMD_COMMAND, 8'($urandom), 16'h0000);
                send_request(lcdns_pkg::CMD_INIT, 8'h00, 16'h0000);
                send_request(lcdns_pkg::CMD_NUMBER, 8'h00, 16'($urandom));
            end
        end

        wait_idle();
        repeat (END_SETTLE) @(posedge aclk);

        $display("Checked %0d pulse beats from %0d requests under %0d timing settings,",
                 pulses_checked, requests_seen, settings);
        $display("covering init, byte and number requests, zero timing and a long output stall.");
        if (mismatch_count == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule

/* char_lcd_nibble_sequencer_unit.f */
src/lcdns_pkg.sv
src/lcdns_bin2bcd.sv
src/char_lcd_nibble_sequencer_unit.sv
tb/sv/lcd_pulse_checker.sv
tb/sv/tb_top.sv
